// ===== rtl/core/hbtm_pkg.sv =====
// Shared types, codes and timing constants for the HDQ bit timing master.
package hbtm_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_GAPA = 3'd1,
    PH_LOW  = 3'd2,
    PH_HIGH = 3'd3,
    PH_SAMP = 3'd4,
    PH_GAPB = 3'd5
  } phase_t;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_REG   = 2'd3;

  localparam int TIME_W  = 14;
  localparam int BASE_W  = 7;
  localparam int SCALE_W = 8;

  localparam logic [BASE_W-1:0] BASE_W0_LOW  = 7'd60;
  localparam logic [BASE_W-1:0] BASE_W1_LOW  = 7'd6;
  localparam logic [BASE_W-1:0] BASE_W0_HIGH = 7'd10;
  localparam logic [BASE_W-1:0] BASE_W1_HIGH = 7'd64;
  localparam logic [BASE_W-1:0] BASE_RD_HIGH = 7'd9;
  localparam logic [BASE_W-1:0] BASE_GAP     = 7'd55;

  localparam logic [2:0] LAST_BIT = 3'd7;
  localparam logic [7:0] ADDR_MASK = 8'h7f;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd1;

  // Unscaled length of the segment that phase p opens.
  function automatic logic [BASE_W-1:0] seg_base(phase_t p, logic rd, logic bit_val);
    logic [BASE_W-1:0] b;
    case (p)
      PH_LOW:  b = (rd || bit_val) ? BASE_W1_LOW : BASE_W0_LOW;
      PH_HIGH: b = rd ? BASE_RD_HIGH : (bit_val ? BASE_W1_HIGH : BASE_W0_HIGH);
      default: b = BASE_GAP;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/hdq_bit_timing_master.sv =====
// HDQ single-wire master: one time unit of the bit waveform per request.
// A request is held in the input register, and its result in the result register.
// Throughput: one request per cycle unless a result waits on out_ready; the state update
//   and the one 7x8 multiply for the segment length fit in the single stage between the two registers.
// Reset (rst, synchronous): idle, no pending request or result, delay_scale = 1.
// Config writes are always accepted and take effect on the next segment.
module hdq_bit_timing_master (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  mode,
  input  logic [7:0]                  data_byte,
  input  logic                        line_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        line_low,
  output logic                        busy_res,
  output logic [7:0]                  read_value,
  output logic                        read_done,
  output logic                        rejected,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hbtm_pkg::SCALE_W-1:0] cfg_data
);
  import hbtm_pkg::*;

  // input register
  logic       s1_valid;
  logic [1:0] s1_mode;
  logic [7:0] s1_data;
  logic       s1_line;

  // block state
  logic [SCALE_W-1:0] delay_scale;
  logic [TIME_W-1:0]  time_left, time_left_next;
  phase_t             phase, phase_next;
  logic [2:0]         bit_index, bit_index_next;
  logic [7:0]         shift_bits, shift_bits_next;
  logic               reading, reading_next;
  logic               active, active_next;

  // result values for this unit
  logic       low_c, busy_c, done_c, rej_c;
  logic [7:0] rv_c;

  logic advance;

  // segment length unit
  logic                do_enter;
  phase_t              enter_ph;
  logic                enter_bit;
  logic [SCALE_W-1:0]  scale_eff;
  logic [BASE_W+SCALE_W-1:0] seg_prod;

  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  assign scale_eff = (delay_scale == '0) ? SCALE_RESET : delay_scale;
  assign seg_prod  = (BASE_W+SCALE_W)'(seg_base(enter_ph, reading_next, enter_bit)) *
                     (BASE_W+SCALE_W)'(scale_eff);

  always_comb begin
    logic           start;
    logic           cur_active;
    phase_t         cur_ph;
    logic [TIME_W-1:0] tl_dec;
    logic           bit_end;

    active_next     = active;
    reading_next    = reading;
    bit_index_next  = bit_index;
    shift_bits_next = shift_bits;
    phase_next      = phase;
    time_left_next  = time_left;
    do_enter        = 1'b0;
    enter_ph        = PH_GAPB;
    enter_bit       = 1'b0;
    low_c  = 1'b0;
    busy_c = 1'b0;
    done_c = 1'b0;
    rej_c  = 1'b0;
    rv_c   = '0;
    bit_end = 1'b0;
    tl_dec  = '0;

    start      = !active && (s1_mode != MODE_TICK);
    rej_c      = active && (s1_mode != MODE_TICK);
    cur_active = active || start;
    cur_ph     = phase;

    if (start) begin
      // the accepting unit is the first unit of bit 0; its segment is never shorter than 6
      active_next     = 1'b1;
      reading_next    = (s1_mode == MODE_READ);
      bit_index_next  = '0;
      shift_bits_next = (s1_mode == MODE_WRITE) ? s1_data :
                        (s1_mode == MODE_REG) ? (s1_data & ADDR_MASK) : 8'h00;
      enter_ph        = (s1_mode == MODE_READ) ? PH_GAPA : PH_LOW;
      enter_bit       = shift_bits_next[0];
      cur_ph          = enter_ph;
      busy_c          = 1'b1;
      low_c           = (enter_ph == PH_LOW);
      phase_next      = enter_ph;
      time_left_next  = seg_prod[TIME_W-1:0] - TIME_W'(1);
    end else if (cur_active) begin
      busy_c = 1'b1;
      low_c  = (cur_ph == PH_LOW);
      tl_dec = (time_left != '0) ? time_left - TIME_W'(1) : '0;
      time_left_next = tl_dec;
      if (tl_dec == '0) begin
        unique case (phase)
          PH_GAPA: begin
            do_enter  = 1'b1;
            enter_ph  = PH_LOW;
            enter_bit = shift_bits[bit_index];
          end
          PH_LOW: begin
            do_enter  = 1'b1;
            enter_ph  = PH_HIGH;
            enter_bit = shift_bits[bit_index];
          end
          PH_HIGH: begin
            if (reading) begin
              shift_bits_next = shift_bits | (8'(s1_line) << bit_index);
              do_enter        = 1'b1;
              enter_ph        = PH_SAMP;
            end else begin
              bit_end = 1'b1;
            end
          end
          PH_SAMP: begin
            do_enter = 1'b1;
            enter_ph = PH_GAPB;
          end
          default: bit_end = 1'b1;
        endcase
        if (bit_end) begin
          if (bit_index >= LAST_BIT) begin
            if (reading) begin
              done_c = 1'b1;
              rv_c   = shift_bits;
            end
            active_next    = 1'b0;
            phase_next     = PH_IDLE;
            time_left_next = '0;
            bit_index_next = '0;
          end else begin
            bit_index_next = bit_index + 3'd1;
            do_enter       = 1'b1;
            enter_ph       = reading ? PH_GAPA : PH_LOW;
            enter_bit      = shift_bits[bit_index_next];
          end
        end
        if (do_enter) begin
          phase_next     = enter_ph;
          time_left_next = seg_prod[TIME_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      delay_scale <= SCALE_RESET;
      time_left   <= '0;
      phase       <= PH_IDLE;
      bit_index   <= '0;
      shift_bits  <= '0;
      reading     <= 1'b0;
      active      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delay_scale <= cfg_data;
      end
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid  <= 1'b1;
        time_left  <= time_left_next;
        phase      <= phase_next;
        bit_index  <= bit_index_next;
        shift_bits <= shift_bits_next;
        reading    <= reading_next;
        active     <= active_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode;
      s1_data <= data_byte;
      s1_line <= line_in;
    end
    if (advance) begin
      line_low   <= low_c;
      busy_res   <= busy_c;
      read_value <= rv_c;
      read_done  <= done_c;
      rejected   <= rej_c;
    end
  end

  a_active_has_phase: assert property (@(posedge clk) disable iff (rst)
    active |-> (phase != PH_IDLE))
    else $error("active without a bit phase");

  a_idle_no_time: assert property (@(posedge clk) disable iff (rst)
    !active |-> (time_left == '0) && (bit_index == '0))
    else $error("idle with leftover timing state");

  a_done_is_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_done) |-> busy_res)
    else $error("read_done outside an operation");

  // a reject can land in the unit that completes a read
  a_reject_is_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rejected) |-> busy_res)
    else $error("reject while idle");

  a_scale_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (delay_scale == $past(cfg_data)))
    else $error("scale write lost");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the HDQ bit timing master: predictor, driver, monitor.
module tb;
  import hbtm_pkg::*;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic       line_in;
  } hdq_req_t;

  typedef struct packed {
    logic       line_low;
    logic       busy_res;
    logic [7:0] read_value;
    logic       read_done;
    logic       rejected;
  } line_unit_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         mode = MODE_TICK;
  logic [7:0]         data_byte = 8'h00;
  logic               line_in = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               line_low;
  logic               busy_res;
  logic [7:0]         read_value;
  logic               read_done;
  logic               rejected;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SCALE_W-1:0] cfg_data = '0;

  hdq_bit_timing_master DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .data_byte  (data_byte),
    .line_in    (line_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .line_low   (line_low),
    .busy_res   (busy_res),
    .read_value (read_value),
    .read_done  (read_done),
    .rejected   (rejected),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // requests waiting to be sent, and line units predicted but not yet seen
  hdq_req_t   tx_reqs[$];
  line_unit_t want_units[$];

  logic in_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned n_units = 0;
  int unsigned n_rej = 0;
  int unsigned n_reads = 0;
  int unsigned fails = 0;

  // predictor state
  logic [SCALE_W-1:0] m_scale;
  logic [TIME_W-1:0]  m_left;
  phase_t             m_phase;
  logic [2:0]         m_bit;
  logic [7:0]         m_shift;
  logic               m_rd;
  logic               m_active;

  // Start a waveform segment; its length uses the scale in force right now.
  task automatic open_seg(input phase_t p);
    logic [BASE_W-1:0]  base;
    logic [SCALE_W-1:0] s;
    logic               bit_val;
    bit_val = m_shift[m_bit];
    case (p)
      PH_LOW:  base = (m_rd || bit_val) ? BASE_W1_LOW : BASE_W0_LOW;
      PH_HIGH: base = m_rd ? BASE_RD_HIGH : (bit_val ? BASE_W1_HIGH : BASE_W0_HIGH);
      default: base = BASE_GAP;
    endcase
    s = (m_scale == '0) ? SCALE_W'(1) : m_scale;
    m_phase = p;
    m_left = TIME_W'(base) * TIME_W'(s);
  endtask

  // One time unit of the line waveform.
  task automatic hdq_unit_step(input hdq_req_t r, output line_unit_t u);
    logic bit_end;
    u = '0;
    bit_end = 1'b0;
    if (!m_active) begin
      if (r.mode != MODE_TICK) begin
        m_active = 1'b1;
        m_rd = (r.mode == MODE_READ);
        m_bit = '0;
        case (r.mode)
          MODE_WRITE: m_shift = r.data_byte;
          MODE_REG:   m_shift = r.data_byte & ADDR_MASK;
          default:    m_shift = '0;
        endcase
        open_seg(m_rd ? PH_GAPA : PH_LOW);
      end
    end else if (r.mode != MODE_TICK) begin
      u.rejected = 1'b1;
    end
    if (m_active) begin
      u.busy_res = 1'b1;
      u.line_low = (m_phase == PH_LOW);
      if (m_left != '0) m_left = m_left - 1'b1;
      if (m_left == '0) begin
        case (m_phase)
          PH_GAPA: open_seg(PH_LOW);
          PH_LOW:  open_seg(PH_HIGH);
          PH_HIGH: begin
            if (m_rd) begin
              m_shift[m_bit] = m_shift[m_bit] | r.line_in;
              open_seg(PH_SAMP);
            end else begin
              bit_end = 1'b1;
            end
          end
          PH_SAMP: open_seg(PH_GAPB);
          default: bit_end = 1'b1;
        endcase
        if (bit_end) begin
          if (m_bit == LAST_BIT) begin
            if (m_rd) begin
              u.read_done = 1'b1;
              u.read_value = m_shift;
            end
            m_active = 1'b0;
            m_phase = PH_IDLE;
            m_left = '0;
            m_bit = '0;
          end else begin
            m_bit = m_bit + 1'b1;
            open_seg(m_rd ? PH_GAPA : PH_LOW);
          end
        end
      end
    end
  endtask

  // Driver: request side and result-side backpressure, both at the falling edge.
  always @(negedge clk) begin
    hdq_req_t nxt;
    if (!rst) begin
      if (!in_valid || in_fire) begin
        if (tx_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = tx_reqs.pop_front();
          in_valid  <= 1'b1;
          mode      <= nxt.mode;
          data_byte <= nxt.data_byte;
          line_in   <= nxt.line_in;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: checks results first, then predicts for a request taken at this edge.
  always @(posedge clk) begin
    line_unit_t got;
    line_unit_t want;
    line_unit_t fresh;
    if (rst) begin
      in_fire  <= 1'b0;
      cfg_fire <= 1'b0;
      m_scale  = SCALE_RESET;
      m_left   = '0;
      m_phase  = PH_IDLE;
      m_bit    = '0;
      m_shift  = '0;
      m_rd     = 1'b0;
      m_active = 1'b0;
    end else begin
      in_fire  <= in_valid && in_ready;
      cfg_fire <= cfg_valid && cfg_ready;
      if (out_valid && out_ready) begin
        got = {line_low, busy_res, read_value, read_done, rejected};
        n_units++;
        if (want_units.size() == 0) begin
          if (fails < 10) $display("unexpected result at %0t: %p", $realtime, got);
          fails++;
        end else begin
          want = want_units.pop_front();
          if (got.line_low !== want.line_low || got.busy_res !== want.busy_res ||
              got.read_value !== want.read_value || got.read_done !== want.read_done ||
              got.rejected !== want.rejected) begin
            if (fails < 10)
              $display("mismatch at %0t unit %0d: exp %p got %p", $realtime, n_units, want, got);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) m_scale = cfg_data;
      if (in_valid && in_ready) begin
        hdq_unit_step({mode, data_byte, line_in}, fresh);
        want_units.push_back(fresh);
        n_taken++;
        if (fresh.rejected) n_rej++;
        if (fresh.read_done) n_reads++;
      end
    end
  end

  task automatic queue_req(input logic [1:0] md, input logic [7:0] db, input logic lv);
    tx_reqs.push_back({md, db, lv});
    n_queued++;
  endtask

  // Sender holds off until every request sent so far has its result back.
  task automatic drain();
    while (n_taken != n_queued || want_units.size() != 0) @(negedge clk);
  endtask

  task automatic write_scale(input logic [SCALE_W-1:0] v);
    drain();
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(negedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
  endtask

  // Mostly ticks; an occasional command either starts a byte or gets rejected.
  task automatic add_random(input int n, input int unsigned idle_pct,
                            input int unsigned stall_pct);
    logic [1:0] md;
    @(posedge clk);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      md = ($urandom_range(99) < 3) ? 2'($urandom_range(3, 1)) : MODE_TICK;
      queue_req(md, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // idle ticks, then a register command with bit 7 set, then commands while busy
    queue_req(MODE_TICK, 8'hff, 1'b1);
    queue_req(MODE_TICK, 8'h00, 1'b0);
    queue_req(MODE_REG, 8'hff, 1'b0);
    queue_req(MODE_READ, 8'h00, 1'b1);
    queue_req(MODE_WRITE, 8'haa, 1'b0);
    queue_req(MODE_REG, 8'h55, 1'b1);
    for (int i = 0; i < 14; i++) queue_req(MODE_TICK, 8'(i * 37), 1'(i));

    write_scale(8'd0);      // zero scale acts as one
    add_random(550, 75, 0);
    write_scale(8'd1);
    add_random(550, 0, 75);
    write_scale(8'd2);
    add_random(350, 29, 29);
    write_scale(8'd255);
    add_random(180, 0, 0);

    drain();
    repeat (10) @(negedge clk);
    $display("run covered %0d requests and %0d results: %0d rejected commands, %0d reads done",
             n_taken, n_units, n_rej, n_reads);
    $display("scales 1, 0, 2 and 255; paced free, sender idle, receiver stall, and both");
    if (fails == 0 && want_units.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", want_units.size());
    $display("status: fail");
    $finish;
  end

endmodule
